// ----- rtl/core/sbc_pkg.sv -----
// Shared types, codes and code tables for the SEC-DED byte codec.
`default_nettype none

package sbc_pkg;

  // Command codes carried in the command field of an input item.
  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  // Status codes reported with every result item.
  localparam logic [1:0] ST_CLEAN     = 2'd0;
  localparam logic [1:0] ST_CORRECTED = 2'd1;
  localparam logic [1:0] ST_UNCORR    = 2'd2;

  localparam int unsigned DataW = 8;
  localparam int unsigned CodeW = 18;
  localparam int unsigned NumCodeBits = 13;
  localparam int unsigned SynW = 5;

  // Per data bit contributions to the mid and low codeword bytes. The high
  // byte only takes data bit 7 into its bit 0.
  localparam logic [7:0] EncMid [DataW] = '{
    8'h00, 8'h01, 8'h02, 8'h08, 8'h10, 8'h60, 8'h80, 8'h00
  };
  localparam logic [7:0] EncLow [DataW] = '{
    8'h77, 8'h34, 8'h32, 8'h31, 8'h26, 8'h25, 8'h13, 8'h07
  };

  // Parity check column of each of the 13 code bits after the filler bits
  // are stripped. All columns are distinct and nonzero.
  localparam logic [SynW-1:0] SynCol [NumCodeBits] = '{
    5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1f, 5'h1c, 5'h1a,
    5'h19, 5'h16, 5'h15, 5'h0b, 5'h07
  };

  typedef struct packed {
    logic             command;
    logic [DataW-1:0] data_byte;
    logic [CodeW-1:0] code_word_in;
  } in_item_t;

  typedef struct packed {
    logic [CodeW-1:0] code_word_out;
    logic [DataW-1:0] decoded_byte;
    logic [1:0]       status;
  } out_item_t;

  // Result of the decoder handed to the top level.
  typedef struct packed {
    logic [DataW-1:0] data_byte;
    logic [1:0]       status;
  } dec_res_t;

endpackage

`default_nettype wire

// ----- rtl/core/sbc_encoder.sv -----
// Encoder: data byte to 18-bit codeword with parity and filler bits.
`default_nettype none

module sbc_encoder (
  input  logic [sbc_pkg::DataW-1:0] data_i,
  output logic [sbc_pkg::CodeW-1:0] code_word_o
);

  logic [1:0] hi;
  logic [7:0] mid;
  logic [7:0] lo;

  always_comb begin
    hi  = {1'b0, data_i[7]};
    mid = '0;
    lo  = '0;
    for (int i = 0; i < sbc_pkg::DataW; i++) begin
      if (data_i[i]) begin
        mid = mid ^ sbc_pkg::EncMid[i];
        lo  = lo ^ sbc_pkg::EncLow[i];
      end
    end
    // Filler bits guarantee a transition where the neighbors are all zero.
    if (lo[3:2] == 2'b00) begin
      lo[3] = 1'b1;
    end
    if (!lo[6] && !mid[0]) begin
      lo[7] = 1'b1;
    end
    if (!mid[3] && !mid[1]) begin
      mid[2] = 1'b1;
    end
    if (!mid[6] && !mid[4]) begin
      mid[5] = 1'b1;
    end
    if (!hi[0]) begin
      hi[1] = 1'b1;
    end
  end

  assign code_word_o = {hi, mid, lo};

endmodule

`default_nettype wire

// ----- rtl/core/sbc_decoder.sv -----
// Decoder: strips filler bits, forms the syndrome and corrects one bit.
`default_nettype none

module sbc_decoder (
  input  logic [sbc_pkg::CodeW-1:0] code_word_i,
  output sbc_pkg::dec_res_t         res_o
);

  logic [sbc_pkg::NumCodeBits-1:0] bits;
  logic [sbc_pkg::NumCodeBits-1:0] flip;
  logic [sbc_pkg::NumCodeBits-1:0] fixed;
  logic [sbc_pkg::SynW-1:0]        syn;

  // Gather the 13 code bits, skipping the five filler positions.
  assign bits = {code_word_i[16], code_word_i[15:14], code_word_i[12:11],
                 code_word_i[9:8], code_word_i[6:4], code_word_i[2:0]};

  always_comb begin
    syn = '0;
    for (int i = 0; i < sbc_pkg::NumCodeBits; i++) begin
      if (bits[i]) begin
        syn = syn ^ sbc_pkg::SynCol[i];
      end
    end
  end

  // Columns are nonzero, so a zero syndrome never selects a bit to flip.
  always_comb begin
    for (int i = 0; i < sbc_pkg::NumCodeBits; i++) begin
      flip[i] = (syn == sbc_pkg::SynCol[i]);
    end
  end

  assign fixed = bits ^ flip;

  always_comb begin
    res_o.data_byte = {fixed[12:8], fixed[7:5]};
    if (syn == '0) begin
      res_o.status = sbc_pkg::ST_CLEAN;
    end else if (|flip) begin
      res_o.status = sbc_pkg::ST_CORRECTED;
    end else begin
      res_o.status = sbc_pkg::ST_UNCORR;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/secded_byte_codec_18bit_core.sv -----
// Top level of the SEC-DED byte codec: input register, codec logic, result register.
`default_nettype none

// Each input item either encodes a data byte into an 18-bit codeword (8 data
// bits, 5 parity bits of an odd-column SEC-DED code and 5 filler bits that
// force transitions) or decodes such a codeword back into a byte, correcting
// one bit error and reporting the outcome in status. An accepted item sits in
// an input register, passes through the encoder or decoder XOR network and
// lands in a result register, from which its result is offered. One item is
// accepted in every cycle, also while a finished result still waits in the
// result register, as long as the input register can move on; in_stall_o
// rises only when both registers are full and the result is stalled. The
// block keeps no state between items, so reset only clears the valid flags
// of the two registers.

module secded_byte_codec_18bit_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sbc_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sbc_pkg::out_item_t out_item_o
);

  logic               in_valid_q;
  sbc_pkg::in_item_t  in_item_q;
  logic               out_valid_q;
  sbc_pkg::out_item_t out_item_q;
  sbc_pkg::out_item_t out_item_d;

  logic                      out_hold;
  logic [sbc_pkg::CodeW-1:0] enc_word;
  sbc_pkg::dec_res_t         dec_res;

  // The result register is blocked only while it holds an item that the
  // receiver stalls; the input register then waits too if it is full.
  assign out_hold   = out_valid_q && out_stall_i;
  assign in_stall_o = in_valid_q && out_hold;

  sbc_encoder u_enc (
    .data_i      (in_item_q.data_byte),
    .code_word_o (enc_word)
  );

  sbc_decoder u_dec (
    .code_word_i (in_item_q.code_word_in),
    .res_o       (dec_res)
  );

  // Fields that do not belong to the chosen operation read as zero.
  always_comb begin
    if (in_item_q.command == sbc_pkg::CMD_DECODE) begin
      out_item_d.code_word_out = '0;
      out_item_d.decoded_byte  = dec_res.data_byte;
      out_item_d.status        = dec_res.status;
    end else begin
      out_item_d.code_word_out = enc_word;
      out_item_d.decoded_byte  = '0;
      out_item_d.status        = sbc_pkg::ST_CLEAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (!out_hold) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_item_q <= in_item_i;
    end
    if (!out_hold && in_valid_q) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

// ----- rtl/core/sbc_checker.sv -----
// Port-level checker for the codec top level and its bind statement.
`default_nettype none

module sbc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input sbc_pkg::out_item_t out_item_o
);

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed or was dropped");

  // The input side is only held off while the result side is stalled.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled result");

  // An accepted item reaches the result register when the path is free.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !(out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("accepted item did not produce a result");

  // Encode results carry a clean status, no byte, and exactly one of the
  // two high bits set by the filler rule.
  a_encode_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.code_word_out != '0) |->
      (out_item_o.decoded_byte == '0) && (out_item_o.status == sbc_pkg::ST_CLEAN)
      && (out_item_o.code_word_out[17] ^ out_item_o.code_word_out[16]))
    else $error("malformed encode result");

endmodule

bind secded_byte_codec_18bit_core sbc_checker u_sbc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire
